[src/srmp_pkg.sv]
// shared constants for the stepper trapezoid ramp generator
package srmp_pkg;

  localparam int unsigned COUNT_BITS_DEF = 15;
  localparam int unsigned DELAY_BITS_DEF = 16;

  localparam int unsigned STEPS_W   = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_DLY_W = 16;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned TERM_W    = IDX_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY     = 1'b1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_W-1:0] INIT_DELAY_RST = 16'd1600;
  localparam logic [CFG_W-1:0] MIN_DELAY_RST  = 16'd200;

endpackage

[src/srmp_if.sv]
// valid/ready channels for command items and result items
interface srmp_in_if;
  import srmp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [STEPS_W-1:0] steps;

  modport source (output valid, output op, output steps, input ready);
  modport sink (input valid, input op, input steps, output ready);
endinterface

interface srmp_out_if;
  import srmp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 step_pulse;
  logic                 direction;
  logic [OUT_DLY_W-1:0] next_delay;
  logic                 done_res;
  logic                 ticking;

  modport source (output valid, output step_pulse, output direction, output next_delay,
                  output done_res, output ticking, input ready);
  modport sink (input valid, input step_pulse, input direction, input next_delay,
                input done_res, input ticking, output ready);
endinterface

[src/srmp_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits
module srmp_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 18,
  parameter int unsigned QUO_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);
  import srmp_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [QUO_W-1:0] bits_q, bits_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, bits_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    bits_d = bits_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      rem_d  = DEN_W'(num_i >> QUO_W);
      den_d  = den_i;
      bits_d = num_i[QUO_W-1:0];
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d  = cnt_q - 1'b1;
        rem_d  = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
        bits_d = {bits_q[QUO_W-2:0], ge};
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    bits_q <= bits_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = bits_q;

endmodule

[src/stepper_trapezoid_ramp.sv]
// Stepper pulse generator with a trapezoidal ramp. A start item loads a signed step count and
// the initial delay; each tick item issues one step pulse while steps remain and, while ramping,
// updates the delay with the constant-acceleration recurrence. One item is in work at a time:
// a start item, a tick while idle, or a tick without a ramp update goes through ST_RESULT and
// is ready for the next item once its result is in the output register. A tick that updates
// the delay first runs a restoring division, one quotient bit per cycle, in ST_DIV_WAIT. The
// result waits in that register; a slow consumer holds the next item and all later ones.
module stepper_trapezoid_ramp #(
  parameter int unsigned COUNT_BITS = srmp_pkg::COUNT_BITS_DEF,
  parameter int unsigned DELAY_BITS = srmp_pkg::DELAY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [srmp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [srmp_pkg::CFG_W-1:0]     cfg_data_i,
  srmp_in_if.sink                        in_if,
  srmp_out_if.source                     out_if
);
  import srmp_pkg::*;

  localparam int unsigned NUM_W = DELAY_BITS + TERM_W;
  localparam int unsigned QUO_W = DELAY_BITS + 1;
  localparam int unsigned MAG_W = STEPS_W + 1;
  localparam logic [MAG_W-1:0] MAG_BASE = MAG_W'(1) << STEPS_W;
  localparam logic [DELAY_BITS-1:0] INTERVAL_RST =
    ((INIT_DELAY_RST >> DELAY_BITS) != '0) ? '1 : DELAY_BITS'(INIT_DELAY_RST);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RESULT
  } state_e;

  state_e                state_q, state_d;
  logic [CFG_W-1:0]      init_delay_q, init_delay_d;
  logic [CFG_W-1:0]      min_delay_q, min_delay_d;
  logic                  dir_q, dir_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] issued_q, issued_d;
  logic [COUNT_BITS-1:0] rul_q, rul_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [DELAY_BITS-1:0] interval_q, interval_d;
  logic                  finished_q, finished_d;
  logic                  running_q, running_d;
  logic                  pulse_q, pulse_d;
  logic                  ramp_up_q, ramp_up_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_pulse_q, out_pulse_d;
  logic                  out_dir_q, out_dir_d;
  logic [OUT_DLY_W-1:0]  out_delay_q, out_delay_d;
  logic                  out_done_q, out_done_d;
  logic                  out_tick_q, out_tick_d;

  logic                  in_ready;
  logic                  in_accept;
  logic [STEPS_W-1:0]    raw;
  logic                  neg;
  logic [MAG_W-1:0]      mag;
  logic [COUNT_BITS-1:0] total_ld;
  logic                  has_step;
  logic [COUNT_BITS-1:0] issued_tk;
  logic                  down_go;
  logic [IDX_W-1:0]      idx_inc;
  logic [DELAY_BITS-1:0] init_d;
  logic [DELAY_BITS-1:0] floor_d;
  logic [TERM_W-1:0]     term_p;
  logic [TERM_W-1:0]     term_m;
  logic [NUM_W-1:0]      prod;
  logic [NUM_W-1:0]      div_num;
  logic [TERM_W-1:0]     div_den;
  logic                  div_start;
  logic                  div_done;
  logic [QUO_W-1:0]      quo;
  logic [DELAY_BITS-1:0] up_new;
  logic [DELAY_BITS-1:0] down_new;

  assign in_ready  = (state_q == ST_IDLE);
  assign in_accept = in_if.valid && in_ready;

  assign raw      = in_if.steps;
  assign neg      = raw[STEPS_W-1];
  assign mag      = neg ? MAG_W'(MAG_BASE - {1'b0, raw}) : {1'b0, raw};
  assign total_ld = ((mag >> COUNT_BITS) != '0) ? '1 : COUNT_BITS'(mag);

  assign has_step  = issued_q < total_q;
  assign issued_tk = has_step ? COUNT_BITS'(issued_q + 1'b1) : issued_q;
  assign down_go   = issued_tk >= COUNT_BITS'(total_q - rul_q);
  assign idx_inc   = (idx_q != '1) ? IDX_W'(idx_q + 1'b1) : idx_q;

  assign init_d  = ((init_delay_q >> DELAY_BITS) != '0) ? '1 : DELAY_BITS'(init_delay_q);
  assign floor_d = ((min_delay_q >> DELAY_BITS) != '0) ? '1 : DELAY_BITS'(min_delay_q);

  assign term_p    = TERM_W'({idx_q, 2'b00} + 1'b1);
  assign term_m    = TERM_W'({idx_q, 2'b00} - 1'b1);
  assign prod      = interval_q * term_p;
  assign div_num   = ramp_up_q ? NUM_W'({interval_q, 1'b0}) : prod;
  assign div_den   = ramp_up_q ? term_p : term_m;
  assign div_start = (state_q == ST_DIV_START);

  assign up_new   = DELAY_BITS'(interval_q - quo[DELAY_BITS-1:0]);
  assign down_new = quo[QUO_W-1] ? '1 : quo[DELAY_BITS-1:0];

  srmp_div #(
    .NUM_W (NUM_W),
    .DEN_W (TERM_W),
    .QUO_W (QUO_W)
  ) u_srmp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d      = state_q;
    init_delay_d = init_delay_q;
    min_delay_d  = min_delay_q;
    dir_d        = dir_q;
    total_d      = total_q;
    issued_d     = issued_q;
    rul_d        = rul_q;
    idx_d        = idx_q;
    interval_d   = interval_q;
    finished_d   = finished_q;
    running_d    = running_q;
    pulse_d      = pulse_q;
    ramp_up_d    = ramp_up_q;
    out_valid_d  = out_valid_q;
    out_pulse_d  = out_pulse_q;
    out_dir_d    = out_dir_q;
    out_delay_d  = out_delay_q;
    out_done_d   = out_done_q;
    out_tick_d   = out_tick_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INITIAL_DELAY: init_delay_d = cfg_data_i;
        CFG_MIN_DELAY:     min_delay_d  = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_RESULT;
          pulse_d = 1'b0;
          unique case (in_if.op)
            OP_START: begin
              dir_d      = neg;
              total_d    = total_ld;
              issued_d   = '0;
              idx_d      = '0;
              rul_d      = '0;
              interval_d = init_d;
              finished_d = 1'b0;
              running_d  = 1'b1;
            end
            OP_TICK: begin
              if (running_q) begin
                pulse_d  = has_step;
                issued_d = issued_tk;
                if (!has_step) begin
                  finished_d = 1'b1;
                  running_d  = 1'b0;
                end
                if (rul_q == '0) begin
                  idx_d     = idx_inc;
                  ramp_up_d = 1'b1;
                  state_d   = ST_DIV_START;
                end else if (down_go && (idx_q >= IDX_W'(2))) begin
                  idx_d     = IDX_W'(idx_q - 1'b1);
                  ramp_up_d = 1'b0;
                  state_d   = ST_DIV_START;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV_START: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_RESULT;
          if (ramp_up_q) begin
            if (up_new <= floor_d) begin
              interval_d = floor_d;
              rul_d      = issued_q;
            end else begin
              interval_d = up_new;
            end
            if (issued_q >= (total_q >> 1)) begin
              rul_d = issued_q;
            end
          end else begin
            interval_d = down_new;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_pulse_d = pulse_q;
          out_dir_d   = dir_q;
          out_delay_d = OUT_DLY_W'(interval_q);
          out_done_d  = finished_q;
          out_tick_d  = running_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      init_delay_q <= INIT_DELAY_RST;
      min_delay_q  <= MIN_DELAY_RST;
      dir_q        <= 1'b0;
      total_q      <= '0;
      issued_q     <= '0;
      rul_q        <= '0;
      idx_q        <= '0;
      interval_q   <= INTERVAL_RST;
      finished_q   <= 1'b1;
      running_q    <= 1'b0;
      pulse_q      <= 1'b0;
      ramp_up_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_pulse_q  <= 1'b0;
      out_dir_q    <= 1'b0;
      out_delay_q  <= '0;
      out_done_q   <= 1'b0;
      out_tick_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_delay_q <= init_delay_d;
      min_delay_q  <= min_delay_d;
      dir_q        <= dir_d;
      total_q      <= total_d;
      issued_q     <= issued_d;
      rul_q        <= rul_d;
      idx_q        <= idx_d;
      interval_q   <= interval_d;
      finished_q   <= finished_d;
      running_q    <= running_d;
      pulse_q      <= pulse_d;
      ramp_up_q    <= ramp_up_d;
      out_valid_q  <= out_valid_d;
      out_pulse_q  <= out_pulse_d;
      out_dir_q    <= out_dir_d;
      out_delay_q  <= out_delay_d;
      out_done_q   <= out_done_d;
      out_tick_q   <= out_tick_d;
    end
  end

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid_q;
  assign out_if.step_pulse = out_pulse_q;
  assign out_if.direction  = out_dir_q;
  assign out_if.next_delay = out_delay_q;
  assign out_if.done_res   = out_done_q;
  assign out_if.ticking    = out_tick_q;

endmodule

[src/srmp_checker.sv]
// port-level assertions for the stepper trapezoid ramp generator, with its bind
module srmp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           step_pulse_i,
  input logic                           direction_i,
  input logic [srmp_pkg::OUT_DLY_W-1:0] next_delay_i,
  input logic                           done_res_i,
  input logic                           ticking_i
);
  import srmp_pkg::*;

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(step_pulse_i) &&
      $stable(direction_i) && $stable(next_delay_i) && $stable(done_res_i) &&
      $stable(ticking_i))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while another is in work");

  // a move is never both done and ticking
  a_done_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(done_res_i && ticking_i))
    else $error("done and ticking together");

  // a step pulse only comes while the move keeps ticking
  a_pulse_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && step_pulse_i |-> ticking_i && !done_res_i)
    else $error("step pulse outside a running move");

endmodule

bind stepper_trapezoid_ramp srmp_checker u_srmp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .step_pulse_i (out_if.step_pulse),
  .direction_i  (out_if.direction),
  .next_delay_i (out_if.next_delay),
  .done_res_i   (out_if.done_res),
  .ticking_i    (out_if.ticking)
);
